@@ src/header_running_stats_top_defines.svh @@
// ---------------------------------------------------------------------------
// Header running statistics: assertion macros
// Shared property forms used by the checker; include guarded.
// ---------------------------------------------------------------------------
`ifndef HEADER_RUNNING_STATS_TOP_DEFINES_SVH
`define HEADER_RUNNING_STATS_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define HRS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define HRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/hrs_pkg.sv @@
// ---------------------------------------------------------------------------
// Header running statistics: package
// Field widths, register map, reset values and shared structs.
// ---------------------------------------------------------------------------
package hrs_pkg;

   // parameter defaults
   localparam int unsigned HEADER_SLOTS_DEF = 64;
   localparam int unsigned VALUE_BITS_DEF   = 48;

   // item field widths
   localparam int unsigned SLOT_BITS      = 6;
   localparam int unsigned FIELD_BITS     = 48;
   localparam int unsigned STEP_BITS      = 27;
   localparam int unsigned STEP_OUT_BITS  = 26;
   localparam int unsigned COUNT_BITS     = 32;
   localparam int unsigned LIMIT_BITS     = 16;
   localparam int unsigned SLOTS_REG_BITS = 7;

   // step sentinel: 999.2 in 16-bit fraction, truncated
   localparam logic [STEP_BITS-1:0] NO_STEP = 27'd65483571;

   // configuration port
   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam logic [SLOTS_REG_BITS-1:0] SLOTS_RESET = 7'd64;
   localparam logic [LIMIT_BITS-1:0]     LIMIT_RESET = 16'd131;

   typedef enum logic {
      CSR_SLOTS_IN_USE     = 1'b0,
      CSR_SMALL_STEP_LIMIT = 1'b1
   } csr_index_type;

   // controls into the slot update logic
   typedef struct packed {
      logic                  first_trace;
      logic [LIMIT_BITS-1:0] small_step_limit;
   } hrs_ctrl_type;

   // step status out of the slot update logic
   typedef struct packed {
      logic                     step_found;
      logic [STEP_OUT_BITS-1:0] step_value;
   } hrs_status_type;

endpackage

@@ src/hrs_channels.sv @@
// ---------------------------------------------------------------------------
// Header running statistics: channel interfaces
// Valid/ready item channels for header words and statistics results.
// ---------------------------------------------------------------------------

// header word channel
interface hrs_req_if;
   import hrs_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [SLOT_BITS-1:0]         slot_index;
   logic signed [FIELD_BITS-1:0] header_value;
   logic                         end_of_trace;

   modport source (output valid, slot_index, header_value, end_of_trace, input ready);
   modport sink   (input valid, slot_index, header_value, end_of_trace, output ready);
endinterface

// statistics result channel
interface hrs_rsp_if;
   import hrs_pkg::*;

   logic                         valid;
   logic                         ready;
   logic                         accepted;
   logic [SLOT_BITS-1:0]         slot_echo;
   logic signed [FIELD_BITS-1:0] min_value;
   logic signed [FIELD_BITS-1:0] max_value;
   logic [STEP_OUT_BITS-1:0]     step_value;
   logic                         step_found;
   logic [COUNT_BITS-1:0]        traces_seen;

   modport source (output valid, accepted, slot_echo, min_value, max_value,
                   step_value, step_found, traces_seen, input ready);
   modport sink   (input valid, accepted, slot_echo, min_value, max_value,
                   step_value, step_found, traces_seen, output ready);
endinterface

@@ src/hrs_slot_update.sv @@
// ---------------------------------------------------------------------------
// Header running statistics: slot update
// Next minimum, maximum, previous value and smallest step of one slot.
// ---------------------------------------------------------------------------
module hrs_slot_update #(
   parameter int unsigned VALUE_BITS = hrs_pkg::VALUE_BITS_DEF
) (
   input  logic signed [VALUE_BITS-1:0]  value,
   input  logic signed [VALUE_BITS-1:0]  prev_value,
   input  logic signed [VALUE_BITS-1:0]  min_value,
   input  logic signed [VALUE_BITS-1:0]  max_value,
   input  logic [hrs_pkg::STEP_BITS-1:0] step,
   input  hrs_pkg::hrs_ctrl_type         ctrl,
   output logic signed [VALUE_BITS-1:0]  prev_next,
   output logic signed [VALUE_BITS-1:0]  min_next,
   output logic signed [VALUE_BITS-1:0]  max_next,
   output logic [hrs_pkg::STEP_BITS-1:0] step_next,
   output hrs_pkg::hrs_status_type       status
);
   import hrs_pkg::*;

   localparam int unsigned CMP_BITS =
      (VALUE_BITS + 1 > STEP_BITS) ? VALUE_BITS + 1 : STEP_BITS;

   logic signed [VALUE_BITS:0] diff;
   logic [VALUE_BITS:0]        mag;
   logic [CMP_BITS-1:0]        mag_cmp;
   logic                       record_step;

   // absolute change against the previous trace
   always_comb begin
      diff        = (VALUE_BITS+1)'(value) - (VALUE_BITS+1)'(prev_value);
      mag         = diff[VALUE_BITS] ? (VALUE_BITS+1)'(-diff) : diff;
      mag_cmp     = CMP_BITS'(mag);
      // small changes are ignored; equal values give zero and fall here too
      record_step = (mag_cmp > CMP_BITS'(ctrl.small_step_limit)) &&
                    (mag_cmp < CMP_BITS'(step));
   end

   // next slot contents
   always_comb begin
      prev_next = value;
      if (ctrl.first_trace) begin
         min_next  = value;
         max_next  = value;
         step_next = NO_STEP;
      end else begin
         min_next  = (value < min_value) ? value : min_value;
         max_next  = (value > max_value) ? value : max_value;
         step_next = record_step ? STEP_BITS'(mag) : step;
      end
   end

   // sentinel and zero both mean no step yet
   always_comb begin
      status.step_found = (step_next != '0) && (step_next < NO_STEP);
      status.step_value = status.step_found ? step_next[STEP_OUT_BITS-1:0] : '0;
   end

endmodule

@@ src/header_running_stats_top.sv @@
// ---------------------------------------------------------------------------
// Header running statistics: top level
// Per-slot running min, max and smallest step over trace header words.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one header word per item (slot, value, end-of-trace
//   mark); rsp_chan returns one result item per word with the slot's updated
//   statistics and the trace count after that word. Both are valid/ready.
//   Words for slots at or above slots_in_use come back with accepted low and
//   zero statistics; end-of-trace still counts them if slots_in_use is not
//   above HEADER_SLOTS. Words pass the input stage and the result register;
//   one item per cycle while rsp_ready is high, also for repeated words to the
//   same slot: the memory is read on acceptance and a bypass register forwards
//   the last write. When rsp_ready is low the result register holds; one more
//   item waits in the input stage and then req_ready falls, so nothing is
//   lost. Reset clears the pipeline valids, the trace count and the registers
//   (slots_in_use 64, small_step_limit 131). Slot memory is not cleared: the
//   first trace must write every slot before it is used (not enforced).
//   Registers: byte 0 slots_in_use, byte 4 small_step_limit (APB, no wait).
// ---------------------------------------------------------------------------
module header_running_stats_top #(
   parameter int unsigned HEADER_SLOTS = hrs_pkg::HEADER_SLOTS_DEF,
   parameter int unsigned VALUE_BITS   = hrs_pkg::VALUE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   hrs_req_if.sink                           req_chan,
   hrs_rsp_if.source                         rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [hrs_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [hrs_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [hrs_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                              pready
);
   import hrs_pkg::*;

   localparam int unsigned ADDR_BITS = (HEADER_SLOTS > 1) ? $clog2(HEADER_SLOTS) : 1;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] prev;
      logic signed [VALUE_BITS-1:0] min;
      logic signed [VALUE_BITS-1:0] max;
      logic [STEP_BITS-1:0]         step;
   } slot_entry_type;

   // configuration registers
   logic [SLOTS_REG_BITS-1:0] slots_ff, slots_in;
   logic [LIMIT_BITS-1:0]     limit_ff, limit_in;
   logic                      csr_write;
   csr_index_type             csr_index;

   // input stage
   logic                         s1_valid_ff, s1_valid_in;
   logic [SLOT_BITS-1:0]         s1_slot_ff;
   logic signed [VALUE_BITS-1:0] s1_value_ff;
   logic                         s1_eot_ff;
   slot_entry_type               rd_ff;

   // slot memory and write bypass
   slot_entry_type               slot_mem_ff [HEADER_SLOTS];
   logic                         fwd_valid_ff, fwd_valid_in;
   logic [ADDR_BITS-1:0]         fwd_addr_ff;
   slot_entry_type               fwd_entry_ff;

   // trace counter
   logic [COUNT_BITS-1:0]        count_ff, count_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_accepted_ff;
   logic [SLOT_BITS-1:0]         rsp_slot_ff;
   logic signed [FIELD_BITS-1:0] rsp_min_ff, rsp_max_ff;
   logic [STEP_OUT_BITS-1:0]     rsp_step_ff;
   logic                         rsp_found_ff;
   logic [COUNT_BITS-1:0]        rsp_count_ff;

   // datapath
   logic                         s1_adv, req_fire, enabled, s1_take, wr_en;
   logic [ADDR_BITS-1:0]         rd_addr, s1_addr;
   logic signed [63:0]           in_value_wide, min_wide, max_wide;
   logic signed [VALUE_BITS-1:0] in_value;
   slot_entry_type               cur_entry, new_entry;
   hrs_ctrl_type                 ctrl;
   hrs_status_type               status;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = csr_index_type'(paddr[2]);

   always_comb begin
      slots_in = slots_ff;
      limit_in = limit_ff;
      prdata   = '0;
      unique case (csr_index)
         CSR_SLOTS_IN_USE: begin
            prdata = CSR_DATA_BITS'(slots_ff);
            if (csr_write) slots_in = pwdata[SLOTS_REG_BITS-1:0];
         end
         CSR_SMALL_STEP_LIMIT: begin
            prdata = CSR_DATA_BITS'(limit_ff);
            if (csr_write) limit_in = pwdata[LIMIT_BITS-1:0];
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= SLOTS_RESET;
         limit_ff <= LIMIT_RESET;
      end else begin
         slots_ff <= slots_in;
         limit_ff <= limit_in;
      end
   end

   // ---------------- handshake ----------------
   assign s1_adv         = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign s1_valid_in    = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in   = s1_adv ? s1_valid_ff : rsp_valid_ff;

   // value narrowed or widened to the stored width
   assign in_value_wide = 64'(req_chan.header_value);
   assign in_value      = VALUE_BITS'(in_value_wide);
   assign rd_addr       = ADDR_BITS'(32'(req_chan.slot_index));
   assign s1_addr       = ADDR_BITS'(32'(s1_slot_ff));

   // ---------------- input stage ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_slot_ff  <= req_chan.slot_index;
         s1_value_ff <= in_value;
         s1_eot_ff   <= req_chan.end_of_trace;
      end
   end

   // ---------------- slot memory ----------------
   always_ff @(posedge clock) begin
      if (wr_en) slot_mem_ff[s1_addr] <= new_entry;
      if (req_fire) rd_ff <= slot_mem_ff[rd_addr];
   end

   // last write kept for a word that read the slot in the same cycle
   assign fwd_valid_in = wr_en ? 1'b1 : fwd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_addr_ff  <= s1_addr;
         fwd_entry_ff <= new_entry;
      end
   end

   // ---------------- slot update ----------------
   assign enabled = 32'(slots_ff) <= HEADER_SLOTS;
   assign s1_take = enabled && ({1'b0, s1_slot_ff} < slots_ff) &&
                    (32'(s1_slot_ff) < HEADER_SLOTS);
   assign wr_en   = s1_valid_ff && s1_adv && s1_take;

   assign cur_entry = (fwd_valid_ff && (fwd_addr_ff == s1_addr)) ? fwd_entry_ff : rd_ff;

   assign ctrl.first_trace      = (count_ff == '0);
   assign ctrl.small_step_limit = limit_ff;

   hrs_slot_update #(
      .VALUE_BITS (VALUE_BITS)
   ) u_update (
      .value      (s1_value_ff),
      .prev_value (cur_entry.prev),
      .min_value  (cur_entry.min),
      .max_value  (cur_entry.max),
      .step       (cur_entry.step),
      .ctrl       (ctrl),
      .prev_next  (new_entry.prev),
      .min_next   (new_entry.min),
      .max_next   (new_entry.max),
      .step_next  (new_entry.step),
      .status     (status)
   );

   // ---------------- trace counter ----------------
   always_comb begin
      count_in = count_ff;
      if (s1_valid_ff && s1_adv && enabled && s1_eot_ff && (count_ff != '1)) begin
         count_in = count_ff + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // ---------------- result register ----------------
   assign min_wide = 64'(new_entry.min);
   assign max_wide = 64'(new_entry.max);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_accepted_ff <= s1_take;
         rsp_slot_ff     <= s1_slot_ff;
         rsp_min_ff      <= s1_take ? FIELD_BITS'(min_wide) : '0;
         rsp_max_ff      <= s1_take ? FIELD_BITS'(max_wide) : '0;
         rsp_step_ff     <= s1_take ? status.step_value : '0;
         rsp_found_ff    <= s1_take && status.step_found;
         rsp_count_ff    <= count_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.accepted    = rsp_accepted_ff;
   assign rsp_chan.slot_echo   = rsp_slot_ff;
   assign rsp_chan.min_value   = rsp_min_ff;
   assign rsp_chan.max_value   = rsp_max_ff;
   assign rsp_chan.step_value  = rsp_step_ff;
   assign rsp_chan.step_found  = rsp_found_ff;
   assign rsp_chan.traces_seen = rsp_count_ff;

endmodule

@@ src/hrs_checker.sv @@
// ---------------------------------------------------------------------------
// Header running statistics: port checker
// Watches the result channel over time; bound to the top level.
// ---------------------------------------------------------------------------
`include "header_running_stats_top_defines.svh"

module hrs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_accepted,
   input logic [hrs_pkg::SLOT_BITS-1:0]       rsp_slot_echo,
   input logic [hrs_pkg::FIELD_BITS-1:0]      rsp_min_value,
   input logic [hrs_pkg::FIELD_BITS-1:0]      rsp_max_value,
   input logic [hrs_pkg::STEP_OUT_BITS-1:0]   rsp_step_value,
   input logic                                rsp_step_found,
   input logic [hrs_pkg::COUNT_BITS-1:0]      rsp_traces_seen
);
   import hrs_pkg::*;

   logic [COUNT_BITS-1:0] last_seen_ff, last_seen_in;
   logic                  rsp_fire;

   // trace count of the last delivered item
   assign rsp_fire     = rsp_valid && rsp_ready;
   assign last_seen_in = rsp_fire ? rsp_traces_seen : last_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seen_ff <= '0;
      end else begin
         last_seen_ff <= last_seen_in;
      end
   end

   // nothing comes out in the cycle after reset
   `HRS_ASSERT_NOW(a_quiet_after_reset, clock, reset, $past(reset), !rsp_valid, "result valid straight after reset")

   // a stalled result stays valid, its slot, trace count and minimum unchanged
   `HRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_slot_echo) && $stable(rsp_traces_seen) && $stable(rsp_min_value), "stalled result changed")

   // trace count never goes back
   `HRS_ASSERT_NOW(a_count_order, clock, reset, rsp_fire, rsp_traces_seen >= last_seen_ff, "trace count went backwards")

   // refused word carries no statistics
   `HRS_ASSERT_NOW(a_refused_clear, clock, reset, rsp_valid && !rsp_accepted, (rsp_min_value == '0) && (rsp_max_value == '0) && (rsp_step_value == '0) && !rsp_step_found, "refused item with statistics")

endmodule

bind header_running_stats_top hrs_checker u_hrs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_accepted    (rsp_chan.accepted),
   .rsp_slot_echo   (rsp_chan.slot_echo),
   .rsp_min_value   (rsp_chan.min_value),
   .rsp_max_value   (rsp_chan.max_value),
   .rsp_step_value  (rsp_chan.step_value),
   .rsp_step_found  (rsp_chan.step_found),
   .rsp_traces_seen (rsp_chan.traces_seen)
);

@@ dv/tb_header_running_stats_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Header running statistics: block testbench
// Sends header words over the request channel, keeps its own per-slot model
// of min, max, previous word and smallest step, and checks every result item
// field by field. Covers the first trace, the step rules, refused words and
// register settings, back-pressure, then random traces, with and without idling.
// ---------------------------------------------------------------------------
module tb_header_running_stats_top;
   import hrs_pkg::*;

   localparam int          CLOCK_PERIOD  = 20;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int          MAX_GAP       = 16;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          SETTLE_CYCLES = 8;

   localparam logic [FIELD_BITS-1:0] VALUE_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [FIELD_BITS-1:0] VALUE_MIN = 48'h8000_0000_0000;

   // one expected result item
   typedef struct packed {
      logic                     accepted;
      logic [SLOT_BITS-1:0]     slot;
      logic [FIELD_BITS-1:0]    min_v;
      logic [FIELD_BITS-1:0]    max_v;
      logic [STEP_OUT_BITS-1:0] step;
      logic                     found;
      logic [COUNT_BITS-1:0]    traces;
   } slot_stats_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   hrs_req_if req_chan ();
   hrs_rsp_if rsp_chan ();

   header_running_stats_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // model state of the block
   logic [FIELD_BITS-1:0]     prev_word   [HEADER_SLOTS_DEF];
   logic [FIELD_BITS-1:0]     low_word    [HEADER_SLOTS_DEF];
   logic [FIELD_BITS-1:0]     high_word   [HEADER_SLOTS_DEF];
   logic [STEP_BITS-1:0]      best_step   [HEADER_SLOTS_DEF];
   bit                        slot_written[HEADER_SLOTS_DEF];
   logic [COUNT_BITS-1:0]     trace_total = '0;
   logic [SLOTS_REG_BITS-1:0] cfg_slots   = SLOTS_RESET;
   logic [LIMIT_BITS-1:0]     cfg_limit   = LIMIT_RESET;

   slot_stats_type stats_due[$];
   int          error_count = 0;
   int          words_sent  = 0;
   int unsigned cycle_count = 0;
   bit          tx_idle     = 1'b1;
   bit          rx_idle     = 1'b1;
   bit          hold_request = 1'b0;

   // update the slot statistics for one accepted word, queue the result
   function automatic void update_slot_stats(logic [SLOT_BITS-1:0] slot,
                                             logic [FIELD_BITS-1:0] word, logic last);
      slot_stats_type        r;
      logic                  enabled;
      logic                  take;
      logic [FIELD_BITS-1:0] key_new;
      logic [FIELD_BITS-1:0] key_old;
      logic [FIELD_BITS-1:0] diff;
      int                    s;
      s       = int'(slot);
      enabled = (32'(cfg_slots) <= HEADER_SLOTS_DEF);
      take    = enabled && ({1'b0, slot} < cfg_slots);
      r       = '0;
      if (take) begin
         if (trace_total == '0) begin
            prev_word[s]    = word;
            low_word[s]     = word;
            high_word[s]    = word;
            best_step[s]    = NO_STEP;
            slot_written[s] = 1'b1;
         end else begin
            // flipping the sign bit gives an unsigned key in signed order
            key_new = word ^ VALUE_MIN;
            key_old = prev_word[s] ^ VALUE_MIN;
            if (key_new < (low_word[s] ^ VALUE_MIN)) low_word[s] = word;
            if (key_new > (high_word[s] ^ VALUE_MIN)) high_word[s] = word;
            if (key_new != key_old) begin
               diff = (key_new > key_old) ? key_new - key_old : key_old - key_new;
               if (diff > FIELD_BITS'(cfg_limit) && diff < FIELD_BITS'(best_step[s]))
                  best_step[s] = diff[STEP_BITS-1:0];
            end
            prev_word[s] = word;
         end
         r.min_v = low_word[s];
         r.max_v = high_word[s];
         if (best_step[s] != '0 && best_step[s] < NO_STEP) begin
            r.step  = best_step[s][STEP_OUT_BITS-1:0];
            r.found = 1'b1;
         end
      end
      // trace count saturates; refused words still count unless disabled
      if (enabled && last && trace_total != '1) trace_total++;
      r.accepted = take;
      r.slot     = slot;
      r.traces   = trace_total;
      stats_due.push_back(r);
   endfunction

   // a word near the slot's previous one, with the odd extreme or wild value
   function automatic logic [FIELD_BITS-1:0] near_value(int s);
      logic [FIELD_BITS-1:0] base;
      logic [FIELD_BITS-1:0] delta;
      base = slot_written[s] ? prev_word[s] : FIELD_BITS'({$urandom, $urandom});
      case ($urandom_range(0, 11))
         0: return FIELD_BITS'({$urandom, $urandom});
         1: begin
            case ($urandom_range(0, 3))
               0:       return VALUE_MAX;
               1:       return VALUE_MIN;
               2:       return '0;
               default: return '1;
            endcase
         end
         2:       return base;
         3:       delta = FIELD_BITS'($urandom_range(0, 32'(cfg_limit)));
         4:       delta = FIELD_BITS'(cfg_limit) + FIELD_BITS'(1);
         5:       delta = FIELD_BITS'($urandom_range(60000000, 70000000));
         6:       delta = FIELD_BITS'(NO_STEP) - FIELD_BITS'($urandom_range(0, 1));
         default: delta = FIELD_BITS'($urandom_range(1, 5000));
      endcase
      return $urandom_range(0, 1) ? base + delta : base - delta;
   endfunction

   // offer one word, wait until it is taken, then predict its result
   task automatic send_word(logic [SLOT_BITS-1:0] slot, logic [FIELD_BITS-1:0] word,
                            logic last);
      int gap;
      gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.slot_index   <= slot;
      req_chan.header_value <= word;
      req_chan.end_of_trace <= last;
      do @(posedge clock); while (!req_chan.ready);
      update_slot_stats(slot, word, last);
      words_sent++;
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (stats_due.size() != 0);
   endtask

   // write one register while idle, then read it back
   task automatic program_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      drain();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == CSR_SLOTS_IN_USE) cfg_slots = value[SLOTS_REG_BITS-1:0];
      else cfg_limit = value[LIMIT_BITS-1:0];
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== value) begin
         error_count++;
         $display("%0t: register %s read back, expected %h, actual %h",
                  $time, idx.name(), value, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // stray word: any slot, sometimes closing a trace
   task automatic send_noise();
      logic [SLOT_BITS-1:0] s;
      s = SLOT_BITS'($urandom());
      send_word(s, near_value(int'(s)), $urandom_range(0, 7) == 0);
   endtask

   // one trace over the slots in use, now and then broken by a dropped or stray word
   task automatic send_trace();
      int n;
      n = int'(cfg_slots);
      for (int i = 0; i < n; i++) begin
         int pick;
         pick = $urandom_range(0, 15);
         if (pick == 0) send_noise();
         else if (pick != 1 || i == n - 1)
            send_word(SLOT_BITS'(i), near_value(i), i == n - 1);
      end
   endtask

   // first trace: words set the slot outright, refused words leave it alone
   task automatic test_first_trace();
      program_register(CSR_SLOTS_IN_USE, 8);
      send_word(3, near_value(3), 1'b0);
      send_word(40, near_value(40), 1'b0);
      send_word(3, VALUE_MIN, 1'b0);
      send_word(7, VALUE_MAX, 1'b0);
      // every slot gets written before the first trace closes
      program_register(CSR_SLOTS_IN_USE, HEADER_SLOTS_DEF);
      for (int i = 0; i < HEADER_SLOTS_DEF; i++)
         send_word(SLOT_BITS'(i), near_value(i), i == HEADER_SLOTS_DEF - 1);
   endtask

   // second trace: extremes, limit boundary, sentinel boundary, kept step
   task automatic test_step_rules();
      send_word(0, VALUE_MAX, 1'b0);
      send_word(1, VALUE_MIN, 1'b0);
      send_word(2, prev_word[2], 1'b0);
      send_word(3, prev_word[3] + FIELD_BITS'(cfg_limit), 1'b0);
      send_word(4, prev_word[4] - FIELD_BITS'(cfg_limit) - FIELD_BITS'(1), 1'b0);
      send_word(5, prev_word[5] + FIELD_BITS'(NO_STEP), 1'b0);
      send_word(5, prev_word[5] + FIELD_BITS'(NO_STEP) - FIELD_BITS'(1), 1'b0);
      // a small change must not clear the step just found
      send_word(4, prev_word[4] + FIELD_BITS'(cfg_limit), 1'b0);
      send_word(4, prev_word[4] + 48'd200, 1'b0);
      send_word(63, '0, 1'b1);
   endtask

   // refused words, no slots in use, and too many slots
   task automatic test_refused_words();
      program_register(CSR_SLOTS_IN_USE, 4);
      send_word(10, near_value(10), 1'b1);
      send_word(3, near_value(3), 1'b0);
      send_word(4, near_value(4), 1'b0);
      program_register(CSR_SLOTS_IN_USE, 0);
      send_word(0, near_value(0), 1'b1);
      program_register(CSR_SLOTS_IN_USE, HEADER_SLOTS_DEF + 1);
      send_word(0, near_value(0), 1'b1);
      program_register(CSR_SLOTS_IN_USE, 127);
      send_word(63, near_value(63), 1'b1);
      send_word(5, near_value(5), 1'b0);
      program_register(CSR_SLOTS_IN_USE, HEADER_SLOTS_DEF);
   endtask

   // long receiver hold while the sender keeps pushing
   task automatic test_backpressure();
      tx_idle      = 1'b0;
      rx_idle      = 1'b1;
      hold_request = 1'b1;
      send_trace();
      drain();
      tx_idle = 1'b1;
   endtask

   task automatic run_random_phase(int slots, int limit, int count, bit tx, bit rx);
      int stop_at;
      program_register(CSR_SLOTS_IN_USE, slots);
      program_register(CSR_SMALL_STEP_LIMIT, limit);
      tx_idle = tx;
      rx_idle = rx;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         if (cfg_slots == '0 || 32'(cfg_slots) > HEADER_SLOTS_DEF ||
             $urandom_range(0, 7) == 0)
            send_noise();
         else
            send_trace();
      end
      drain();
   endtask

   task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endtask

   // result receiver: random stalls, plus one long hold on request
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
         if (hold_request) begin
            gap          = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock);
         while (!(rsp_chan.valid && rsp_chan.ready) && !hold_request);
      end
   end

   // check each result item against the oldest prediction
   always @(posedge clock) begin
      slot_stats_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (stats_due.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result item, expected none, actual slot %0d",
                     $time, rsp_chan.slot_echo);
         end else begin
            want = stats_due.pop_front();
            compare_field("accepted", 64'(want.accepted), 64'(rsp_chan.accepted));
            compare_field("slot_echo", 64'(want.slot), 64'(rsp_chan.slot_echo));
            compare_field("min_value", 64'(want.min_v),
                          64'($unsigned(rsp_chan.min_value)));
            compare_field("max_value", 64'(want.max_v),
                          64'($unsigned(rsp_chan.max_value)));
            compare_field("step_value", 64'(want.step), 64'(rsp_chan.step_value));
            compare_field("step_found", 64'(want.found), 64'(rsp_chan.step_found));
            compare_field("traces_seen", 64'(want.traces), 64'(rsp_chan.traces_seen));
         end
      end
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_header_running_stats_top: FAIL");
         $finish;
      end
   end

   initial begin
      reset                 <= 1'b1;
      psel                  <= 1'b0;
      penable               <= 1'b0;
      pwrite                <= 1'b0;
      paddr                 <= '0;
      pwdata                <= '0;
      req_chan.valid        <= 1'b0;
      req_chan.slot_index   <= '0;
      req_chan.header_value <= '0;
      req_chan.end_of_trace <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_first_trace();
      test_step_rules();
      test_refused_words();
      test_backpressure();

      run_random_phase(HEADER_SLOTS_DEF, LIMIT_RESET, 110, 1'b1, 1'b1);
      run_random_phase(HEADER_SLOTS_DEF, 0, 90, 1'b0, 1'b0);
      run_random_phase(HEADER_SLOTS_DEF, 65535, 55, 1'b1, 1'b0);
      run_random_phase(1, LIMIT_RESET, 50, 1'b0, 1'b1);
      run_random_phase(37, $urandom_range(0, 65535), 90, 1'b1, 1'b1);
      run_random_phase(HEADER_SLOTS_DEF, $urandom_range(0, 2000), 55, 1'b1, 1'b1);
      run_random_phase(100, LIMIT_RESET, 20, 1'b1, 1'b1);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_header_running_stats_top: PASS");
      else
         $display("tb_header_running_stats_top: FAIL");
      $finish;
   end

endmodule

@@ header_running_stats_top.f @@
+incdir+src
src/hrs_pkg.sv
src/hrs_channels.sv
src/hrs_slot_update.sv
src/header_running_stats_top.sv
src/hrs_checker.sv
dv/tb_header_running_stats_top.sv
